// File: hw/rtl/pbse_pkg.sv
// Shared types and op codes for the protobuf scalar byte encoder.
`timescale 1ns / 1ps

package pbse_pkg;

	localparam logic [2:0] OP_VARINT_U32 = 3'd0;
	localparam logic [2:0] OP_VARINT_U64 = 3'd1;
	localparam logic [2:0] OP_SINT32     = 3'd2;
	localparam logic [2:0] OP_FIXED32    = 3'd3;
	localparam logic [2:0] OP_FIXED64    = 3'd4;
	localparam logic [2:0] OP_BOOL       = 3'd5;
	localparam logic [2:0] OP_RAW        = 3'd6;
	localparam logic [2:0] OP_UNUSED     = 3'd7;

	localparam logic [7:0] VARINT_MASK = 8'h7f;
	localparam logic [7:0] VARINT_CONT = 8'h80;
	localparam int         VARINT_BITS = 7;

	typedef struct packed {
		logic [2:0]  op;
		logic [63:0] value;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [15:0] byte_address;
		logic        dropped;
		logic [15:0] space_left;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic step;
	} sh_ctrl_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} sh_stat_t;

	typedef struct packed {
		logic [15:0] addr;
		logic        dropped;
		logic [15:0] space;
	} pos_info_t;

endpackage

// File: hw/rtl/protobuf_scalar_byte_encoder_top.sv
// Top level: sequencer, output register and unit wiring of the encoder.
// An item with N wire bytes (1 to 10) keeps the input stalled until its last byte:
// load into the shift unit on accept, then one byte per cycle unless the output stalls.
// The next item is taken right after the last byte enters the output register.
// Output stall holds the sequencer; op 7 is taken with no output.
// Reset clears capacity, write position and all valid state.
`timescale 1ns / 1ps

module protobuf_scalar_byte_encoder_top #(
	parameter int ADDR_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  pbse_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output pbse_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_data
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t              state_q;
	logic                out_valid_q;
	pbse_pkg::out_item_t out_q;
	pbse_pkg::sh_ctrl_t  sh_ctrl;
	pbse_pkg::sh_stat_t  sh_stat;
	pbse_pkg::pos_info_t pos_info;
	logic                accept;
	logic                can_load;
	logic                valid_op;

	assign in_stall = (state_q == ST_RUN);
	assign accept   = in_valid & ~in_stall;
	assign valid_op = (in_data.op != pbse_pkg::OP_UNUSED);
	assign can_load = ~out_valid_q | ~out_stall;

	assign sh_ctrl.load = accept & valid_op;
	assign sh_ctrl.step = (state_q == ST_RUN) & can_load;

	pbse_shifter u_shifter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (sh_ctrl),
		.item   (in_data),
		.stat   (sh_stat)
	);

	pbse_pos #(
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.step     (sh_ctrl.step),
		.info     (pos_info)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (sh_ctrl.load) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (sh_ctrl.step && sh_stat.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (sh_ctrl.step) begin
				out_valid_q        <= 1'b1;
				out_q.out_byte     <= sh_stat.data;
				out_q.byte_address <= pos_info.addr;
				out_q.dropped      <= pos_info.dropped;
				out_q.space_left   <= pos_info.space;
				out_q.last         <= sh_stat.last;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: hw/rtl/pbse_shifter.sv
// Shared shift unit: holds the value and peels off one wire byte per step.
`timescale 1ns / 1ps

module pbse_shifter (
	input  logic               clk,
	input  logic               arst_n,
	input  pbse_pkg::sh_ctrl_t ctrl,
	input  pbse_pkg::in_item_t item,
	output pbse_pkg::sh_stat_t stat
);

	logic [63:0] val_q;
	logic [3:0]  cnt_q;
	logic        varint_q;
	logic        more;

	assign more = |val_q[63:pbse_pkg::VARINT_BITS];

	always_comb begin
		if (varint_q) begin
			stat.data = (val_q[7:0] & pbse_pkg::VARINT_MASK)
				| (more ? pbse_pkg::VARINT_CONT : 8'h00);
			stat.last = ~more;
		end else begin
			stat.data = val_q[7:0];
			stat.last = (cnt_q == 4'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			varint_q <= 1'b0;
			cnt_q    <= '0;
		end else if (ctrl.load) begin
			unique case (item.op)
				pbse_pkg::OP_VARINT_U32: begin
					varint_q <= 1'b1;
					cnt_q    <= '0;
				end
				pbse_pkg::OP_VARINT_U64: begin
					varint_q <= 1'b1;
					cnt_q    <= '0;
				end
				pbse_pkg::OP_SINT32: begin
					varint_q <= 1'b1;
					cnt_q    <= '0;
				end
				pbse_pkg::OP_FIXED32: begin
					varint_q <= 1'b0;
					cnt_q    <= 4'd4;
				end
				pbse_pkg::OP_FIXED64: begin
					varint_q <= 1'b0;
					cnt_q    <= 4'd8;
				end
				default: begin
					varint_q <= 1'b0;
					cnt_q    <= 4'd1;
				end
			endcase
		end else if (ctrl.step) begin
			cnt_q <= cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			unique case (item.op) inside
				pbse_pkg::OP_VARINT_U64,
				pbse_pkg::OP_FIXED64: val_q <= item.value;
				pbse_pkg::OP_SINT32:  val_q <= {{32{item.value[31]}}, item.value[31:0]};
				pbse_pkg::OP_BOOL:    val_q <= {63'd0, |item.value};
				default:              val_q <= {32'd0, item.value[31:0]};
			endcase
		end else if (ctrl.step) begin
			if (varint_q) begin
				val_q <= val_q >> pbse_pkg::VARINT_BITS;
			end else begin
				val_q <= val_q >> 8;
			end
		end
	end

endmodule

// File: hw/rtl/pbse_pos.sv
// Capacity register and write position tracker.
`timescale 1ns / 1ps

module pbse_pos #(
	parameter int ADDR_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_data,
	input  logic                step,
	output pbse_pkg::pos_info_t info
);

	logic [ADDR_WIDTH-1:0] cap_q;
	logic [ADDR_WIDTH-1:0] pos_q;
	logic [ADDR_WIDTH-1:0] pos_next;
	logic [ADDR_WIDTH-1:0] space;
	logic                  full;

	assign full     = (pos_q >= cap_q);
	assign pos_next = full ? pos_q : pos_q + ADDR_WIDTH'(1);
	assign space    = (cap_q >= pos_next) ? cap_q - pos_next : '0;

	assign info.addr    = 16'(pos_q);
	assign info.dropped = full;
	assign info.space   = 16'(space);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
			pos_q <= '0;
		end else if (cfg_we) begin
			cap_q <= ADDR_WIDTH'(cfg_data);
			pos_q <= '0;
		end else if (step) begin
			pos_q <= pos_next;
		end
	end

endmodule

// File: sim/tb_protobuf_scalar_byte_encoder_top.sv
// Self-checking testbench for the protobuf scalar byte encoder top level.
`timescale 1ns / 1ps

module tb_protobuf_scalar_byte_encoder_top;

	localparam int         IDLE_LIMIT  = 3000;
	localparam int         HOLD_CYCLES = 80;
	localparam int         PHASE_ITEMS = 25;
	localparam int         DIR_ROWS    = 27;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  op;
		logic [63:0] value;
		logic        typed;
		logic [7:0]  byte0;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	pbse_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_stall = 1'b0;
	pbse_pkg::out_item_t out_data;
	logic                cfg_we;
	logic [15:0]         cfg_data;

	logic [15:0]         buf_capacity = 16'd0;
	logic [15:0]         buf_pos = 16'd0;
	pbse_pkg::out_item_t pending_bytes [$];
	pbse_pkg::out_item_t want;
	logic                row_typed;
	logic [7:0]          row_byte0;
	logic                idle_on;
	logic                hold_req = 1'b0;
	logic                hold_ack = 1'b0;
	logic                progress;
	int                  hold_left = 0;
	int                  run_left = 0;
	int                  idle_cycles = 0;
	int                  errors = 0;
	stim_row_t           dir_rows [DIR_ROWS];

	protobuf_scalar_byte_encoder_top #(
		.ADDR_WIDTH(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
		if (errors < 40) begin
			$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, exp_val);
		end
		errors++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 8);
		end
		return $urandom_range(15, 40);
	endfunction

	function automatic logic [2:0] rand_op();
		if ($urandom_range(0, 99) < 4) begin
			return pbse_pkg::OP_UNUSED;
		end
		return 3'($urandom_range(0, 6));
	endfunction

	function automatic logic [63:0] rand_value();
		case ($urandom_range(0, 5))
			0: return {$urandom, $urandom};
			1: return 64'($urandom_range(0, 300));
			2: return (64'd1 << (pbse_pkg::VARINT_BITS * $urandom_range(0, 9)))
				- 64'($urandom_range(0, 1));
			3: return {$urandom, 32'hffff_ffff ^ 32'($urandom_range(0, 255))};
			4: return {$urandom, 1'b1, 31'($urandom)};
			default: return 64'd0;
		endcase
	endfunction

	// Work out the wire bytes of one transfer and advance the buffer position.
	function automatic void predict_item(pbse_pkg::in_item_t it, logic typed, logic [7:0] byte0);
		logic [7:0]          wire_q [$];
		logic [63:0]         v;
		pbse_pkg::out_item_t r;
		v = it.value;
		case (it.op) inside
			pbse_pkg::OP_VARINT_U32, pbse_pkg::OP_VARINT_U64, pbse_pkg::OP_SINT32: begin
				if (it.op == pbse_pkg::OP_VARINT_U32
						|| (it.op == pbse_pkg::OP_SINT32 && !v[31])) begin
					v = {32'd0, v[31:0]};
				end else if (it.op == pbse_pkg::OP_SINT32) begin
					v = {32'hffff_ffff, v[31:0]};
				end
				while ((v >> pbse_pkg::VARINT_BITS) != 0) begin
					wire_q.push_back((v[7:0] & pbse_pkg::VARINT_MASK) | pbse_pkg::VARINT_CONT);
					v = v >> pbse_pkg::VARINT_BITS;
				end
				wire_q.push_back(v[7:0]);
			end
			pbse_pkg::OP_FIXED32: for (int i = 0; i < 4; i++) wire_q.push_back(v[8*i +: 8]);
			pbse_pkg::OP_FIXED64: for (int i = 0; i < 8; i++) wire_q.push_back(v[8*i +: 8]);
			pbse_pkg::OP_BOOL:    wire_q.push_back({7'd0, |v});
			pbse_pkg::OP_RAW:     wire_q.push_back(v[7:0]);
			default: ;
		endcase
		if (typed && wire_q.size() > 0) begin
			wire_q[0] = byte0;
		end
		foreach (wire_q[i]) begin
			r.out_byte     = wire_q[i];
			r.byte_address = buf_pos;
			r.dropped      = (buf_pos >= buf_capacity);
			if (!r.dropped) begin
				buf_pos = buf_pos + 16'd1;
			end
			r.space_left = buf_capacity - buf_pos;
			r.last       = (i == wire_q.size() - 1);
			pending_bytes.push_back(r);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			progress = 1'b0;
			if (cfg_we) begin
				buf_capacity = cfg_data;
				buf_pos      = 16'd0;
				progress     = 1'b1;
			end
			if (in_valid && !in_stall) begin
				predict_item(in_data, row_typed, row_byte0);
				progress = 1'b1;
			end
			if (out_valid && !out_stall) begin
				progress = 1'b1;
				if (pending_bytes.size() == 0) begin
					report_mismatch("unexpected byte", 64'(out_data), 64'd0);
				end else begin
					want = pending_bytes.pop_front();
					if (out_data.out_byte !== want.out_byte)
						report_mismatch("out_byte", 64'(out_data.out_byte),
							64'(want.out_byte));
					if (out_data.byte_address !== want.byte_address)
						report_mismatch("byte_address", 64'(out_data.byte_address),
							64'(want.byte_address));
					if (out_data.dropped !== want.dropped)
						report_mismatch("dropped", 64'(out_data.dropped),
							64'(want.dropped));
					if (out_data.space_left !== want.space_left)
						report_mismatch("space_left", 64'(out_data.space_left),
							64'(want.space_left));
					if (out_data.last !== want.last)
						report_mismatch("last", 64'(out_data.last), 64'(want.last));
				end
			end
			idle_cycles = progress ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
				$display("[protobuf_scalar_byte_encoder_top] ERROR");
				$finish;
			end
		end
	end

	// Output side: random short and long stalls, plus one long hold on request.
	always begin
		@(negedge clk);
		if (hold_req != hold_ack) begin
			hold_ack  = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else if (run_left > 0) begin
			out_stall = 1'b1;
			run_left--;
		end else if (idle_on && $urandom_range(0, 99) < 20) begin
			out_stall = 1'b1;
			run_left  = $urandom_range(0, 99) < 90 ? $urandom_range(0, 2) : $urandom_range(9, 29);
		end else begin
			out_stall = 1'b0;
		end
	end

	task automatic send_item(logic [2:0] op, logic [63:0] value, logic typed, logic [7:0] byte0);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data.op    = op;
		in_data.value = value;
		row_typed     = typed;
		row_byte0     = byte0;
		in_valid      = 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_bytes.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_capacity(logic [15:0] cap);
		drain_results();
		cfg_data = cap;
		cfg_we   = 1'b1;
		@(negedge clk);
		cfg_we   = 1'b0;
	endtask

	initial begin
		logic [15:0] ph_caps [6];
		logic [2:0]  op;
		int          n;
		int          k;
		in_valid     = 1'b0;
		in_data      = '0;
		cfg_we       = 1'b0;
		cfg_data     = 16'd0;
		row_typed    = 1'b0;
		row_byte0    = 8'd0;
		idle_on      = 1'b1;
		arst_n       = 1'b0;
		dir_rows = '{
			'{ROW_ITEM, pbse_pkg::OP_RAW,        64'h0000_0000_0000_00a5, 1'b1, 8'ha5},
			'{ROW_ITEM, pbse_pkg::OP_VARINT_U64, 64'hffff_ffff_ffff_ffff, 1'b1, 8'hff},
			'{ROW_CFG,  pbse_pkg::OP_RAW,        64'd64,                  1'b0, 8'h00},
			'{ROW_ITEM, pbse_pkg::OP_VARINT_U32, 64'h0000_0000_0000_0000, 1'b1, 8'h00},
			'{ROW_ITEM, pbse_pkg::OP_VARINT_U32, 64'h0000_0000_0000_007f, 1'b1, 8'h7f},
			'{ROW_ITEM, pbse_pkg::OP_VARINT_U32, 64'h0000_0000_0000_0080, 1'b1, 8'h80},
			'{ROW_ITEM, pbse_pkg::OP_VARINT_U32, 64'hdead_beef_ffff_ffff, 1'b1, 8'hff},
			'{ROW_ITEM, pbse_pkg::OP_VARINT_U64, 64'h0000_0000_0000_0000, 1'b1, 8'h00},
			'{ROW_ITEM, pbse_pkg::OP_VARINT_U64, 64'hffff_ffff_ffff_ffff, 1'b1, 8'hff},
			'{ROW_ITEM, pbse_pkg::OP_VARINT_U64, 64'h8000_0000_0000_0000, 1'b1, 8'h80},
			'{ROW_ITEM, pbse_pkg::OP_SINT32,     64'h0000_0000_ffff_ffff, 1'b1, 8'hff},
			'{ROW_ITEM, pbse_pkg::OP_SINT32,     64'hffff_ffff_7fff_ffff, 1'b1, 8'hff},
			'{ROW_ITEM, pbse_pkg::OP_SINT32,     64'h0000_0000_8000_0000, 1'b1, 8'h80},
			'{ROW_ITEM, pbse_pkg::OP_SINT32,     64'h1234_5678_0000_0040, 1'b0, 8'h00},
			'{ROW_ITEM, pbse_pkg::OP_FIXED32,    64'hffff_ffff_1234_5678, 1'b1, 8'h78},
			'{ROW_ITEM, pbse_pkg::OP_FIXED64,    64'h0123_4567_89ab_cdef, 1'b1, 8'hef},
			'{ROW_ITEM, pbse_pkg::OP_BOOL,       64'h0000_0000_0000_0000, 1'b1, 8'h00},
			'{ROW_ITEM, pbse_pkg::OP_BOOL,       64'h8000_0000_0000_0000, 1'b1, 8'h01},
			'{ROW_ITEM, pbse_pkg::OP_BOOL,       64'hffff_ffff_ffff_ffff, 1'b1, 8'h01},
			'{ROW_ITEM, pbse_pkg::OP_RAW,        64'hffff_ffff_ffff_ff00, 1'b1, 8'h00},
			'{ROW_ITEM, pbse_pkg::OP_RAW,        64'h0000_0000_0000_00ff, 1'b1, 8'hff},
			'{ROW_ITEM, pbse_pkg::OP_UNUSED,     64'hffff_ffff_ffff_ffff, 1'b0, 8'h00},
			'{ROW_CFG,  pbse_pkg::OP_RAW,        64'd3,                   1'b0, 8'h00},
			'{ROW_ITEM, pbse_pkg::OP_FIXED64,    64'hffff_ffff_ffff_ffff, 1'b1, 8'hff},
			'{ROW_ITEM, pbse_pkg::OP_RAW,        64'h0000_0000_0000_003c, 1'b1, 8'h3c},
			'{ROW_CFG,  pbse_pkg::OP_RAW,        64'd65535,               1'b0, 8'h00},
			'{ROW_ITEM, pbse_pkg::OP_VARINT_U32, 64'h0000_0000_0001_2345, 1'b0, 8'h00}
		};
		ph_caps = '{16'd1, 16'd0, 16'd40, 16'd65535, 16'd300, 16'($urandom_range(2, 2000))};
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				write_capacity(dir_rows[i].value[15:0]);
			end else begin
				send_item(dir_rows[i].op, dir_rows[i].value, dir_rows[i].typed,
					dir_rows[i].byte0);
			end
		end

		for (int ph = 0; ph < 6; ph++) begin
			write_capacity(ph_caps[ph]);
			idle_on = (ph != 2);
			n = 0;
			k = 0;
			while (n < PHASE_ITEMS) begin
				if (ph == 3 && k == 5) begin
					hold_req = ~hold_req;
				end
				if (ph == 4 && k == 15) begin
					drain_results();
				end
				op = rand_op();
				send_item(op, rand_value(), 1'b0, 8'h00);
				if (op != pbse_pkg::OP_UNUSED) begin
					n++;
				end
				k++;
			end
		end
		idle_on = 1'b1;

		@(negedge clk);
		in_valid = 1'b0;
		while (pending_bytes.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (pending_bytes.size() != 0) begin
			report_mismatch("bytes never arrived", 64'(pending_bytes.size()), 64'd0);
		end
		if (errors == 0) begin
			$display("[protobuf_scalar_byte_encoder_top] OK");
		end else begin
			$display("[protobuf_scalar_byte_encoder_top] ERROR");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/pbse_pkg.sv
hw/rtl/pbse_shifter.sv
hw/rtl/pbse_pos.sv
hw/rtl/protobuf_scalar_byte_encoder_top.sv
sim/tb_protobuf_scalar_byte_encoder_top.sv
